FILE: rtl/core/xorshift128_range_random_defines.svh
// ----------------------------------------------------------------------------
// xorshift128 range random: assertion macros
// Shared assertion forms for the checker of the generator's ports.
// ----------------------------------------------------------------------------
`ifndef XORSHIFT128_RANGE_RANDOM_DEFINES_SVH
`define XORSHIFT128_RANGE_RANDOM_DEFINES_SVH

// A property sampled on the rising clock edge and switched off while in reset.
`define XRR_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// While the condition holds, the signal keeps its value into the next cycle.
`define XRR_ASSERT_HOLD(name, clk, rst_n, cond, sig, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
    else $error(msg);

`endif

FILE: rtl/core/xrr_pkg.sv
// ----------------------------------------------------------------------------
// xorshift128 range random: package
// Widths, seeds, shift amounts, codes and shared types of the generator.
// ----------------------------------------------------------------------------
`default_nettype none

package xrr_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned LIMIT_W = 31;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned CNT_W   = $clog2(WORD_W);

  localparam logic [WORD_W-1:0] SEED_X = 32'd123456789;
  localparam logic [WORD_W-1:0] SEED_Y = 32'd362436069;
  localparam logic [WORD_W-1:0] SEED_Z = 32'd521288629;
  localparam logic [WORD_W-1:0] SEED_W = 32'd88675123;

  // Shift amounts of the recurrence: t = x ^ (x << A); w' = w ^ (w >> B) ^ t ^ (t >> C).
  localparam int unsigned SHIFT_A = 11;
  localparam int unsigned SHIFT_B = 19;
  localparam int unsigned SHIFT_C = 8;

  typedef enum logic [KIND_W-1:0] {
    KIND_RESEED = 2'd0,
    KIND_RAW    = 2'd1,
    KIND_RANGE  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_WRITE
  } state_e;

  typedef struct packed {
    logic start;
    logic reseed;
  } step_ctrl_t;

  typedef struct packed {
    logic busy;
    logic first;
    logic last;
    logic dbit;
  } step_stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/xrr_if.sv
// ----------------------------------------------------------------------------
// xorshift128 range random: channel interfaces
// Valid/ready channels for request and result transactions.
// ----------------------------------------------------------------------------
`default_nettype none

interface xrr_in_if
  import xrr_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [WORD_W-1:0]  seed_word;
  logic [LIMIT_W-1:0] range_limit;

  modport source (output valid, output kind, output seed_word, output range_limit,
                  input ready);
  modport sink   (input valid, input kind, input seed_word, input range_limit,
                  output ready);
endinterface

interface xrr_out_if
  import xrr_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] value;
  logic              range_error;

  modport source (output valid, output value, output range_error, input ready);
  modport sink   (input valid, input value, input range_error, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/xrr_step.sv
// ----------------------------------------------------------------------------
// xorshift128 range random: bit-serial step unit
// Holds the four state words and produces the next word one bit per cycle,
// most significant bit first, by rotating x and w past fixed taps.
// ----------------------------------------------------------------------------
`default_nettype none

module xrr_step
  import xrr_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire step_ctrl_t        ctrl_i,
  input  wire logic [WORD_W-1:0] seed_i,
  output      step_stat_t        stat_o,
  output      logic [WORD_W-1:0] word_o
);

  // After c left rotations, bit k = WORD_W-1-c of the original word sits at
  // the top, and its neighbours at these fixed positions.
  localparam int unsigned TAP_W_HI  = (WORD_W - 1 + SHIFT_B) % WORD_W;
  localparam int unsigned TAP_X_LO  = WORD_W - 1 - SHIFT_A;
  localparam int unsigned TAP_X_HI  = (WORD_W - 1 + SHIFT_C) % WORD_W;
  localparam int unsigned TAP_X_MID = WORD_W - 1 + SHIFT_C - SHIFT_A;

  logic [WORD_W-1:0] x_q, x_d, y_q, y_d, z_q, z_d, w_q, w_d;
  logic [WORD_W-2:0] n_q, n_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              w_hi, x_lo, x_mid, t_k, t_hi, dbit, last;

  always_comb begin
    w_hi  = (cnt_q >= CNT_W'(SHIFT_B)) & w_q[TAP_W_HI];
    x_lo  = (cnt_q <= CNT_W'(TAP_X_LO)) & x_q[TAP_X_LO];
    x_mid = (cnt_q <= CNT_W'(TAP_X_MID)) & x_q[TAP_X_MID];
    t_k   = x_q[WORD_W-1] ^ x_lo;
    t_hi  = (cnt_q >= CNT_W'(SHIFT_C)) & (x_q[TAP_X_HI] ^ x_mid);
    dbit  = w_q[WORD_W-1] ^ w_hi ^ t_k ^ t_hi;
    last  = busy_q & (cnt_q == CNT_W'(WORD_W - 1));
  end

  always_comb begin
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    w_d    = w_q;
    n_d    = n_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (ctrl_i.reseed) begin
      x_d = SEED_X;
      y_d = SEED_Y;
      z_d = SEED_Z;
      w_d = seed_i;
    end else if (ctrl_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (busy_q) begin
      cnt_d = cnt_q + CNT_W'(1);
      n_d   = {n_q[WORD_W-3:0], dbit};
      if (last) begin
        // The final rotation brings w back to its original value.
        busy_d = 1'b0;
        x_d    = y_q;
        y_d    = z_q;
        z_d    = {w_q[WORD_W-2:0], w_q[WORD_W-1]};
        w_d    = {n_q, dbit};
      end else begin
        x_d = {x_q[WORD_W-2:0], x_q[WORD_W-1]};
        w_d = {w_q[WORD_W-2:0], w_q[WORD_W-1]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q    <= SEED_X;
      y_q    <= SEED_Y;
      z_q    <= SEED_Z;
      w_q    <= SEED_W;
      cnt_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      x_q    <= x_d;
      y_q    <= y_d;
      z_q    <= z_d;
      w_q    <= w_d;
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d;
  end

  assign stat_o.busy  = busy_q;
  assign stat_o.first = busy_q & (cnt_q == '0);
  assign stat_o.last  = last;
  assign stat_o.dbit  = dbit;
  assign word_o       = w_q;

endmodule

`default_nettype wire

FILE: rtl/core/xrr_mod.sv
// ----------------------------------------------------------------------------
// xorshift128 range random: bit-serial remainder unit
// Restoring division that takes the dividend one bit per cycle while shift_i is
// high, most significant bit first, and keeps only the partial remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module xrr_mod
  import xrr_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               start_i,
  input  wire logic [LIMIT_W-1:0] limit_i,
  input  wire logic               shift_i,
  input  wire logic               bit_i,
  output      logic [LIMIT_W-1:0] rem_o
);

  logic [LIMIT_W-1:0] lim_q, lim_d, rem_q, rem_d;
  logic [LIMIT_W:0]   trial, diff;

  always_comb begin
    trial = {rem_q, bit_i};
    diff  = trial - {1'b0, lim_q};
    lim_d = lim_q;
    rem_d = rem_q;
    if (start_i) begin
      lim_d = limit_i;
      rem_d = '0;
    end else if (shift_i) begin
      // For a non-zero limit the partial remainder stays below it, so the trial fits.
      rem_d = (trial >= {1'b0, lim_q}) ? diff[LIMIT_W-1:0] : trial[LIMIT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    lim_q <= lim_d;
    rem_q <= rem_d;
  end

  assign rem_o = rem_q;

endmodule

`default_nettype wire

FILE: rtl/core/xorshift128_range_random.sv
// ----------------------------------------------------------------------------
// xorshift128 range random generator
// Top level: request handshake, sequencing and result register.
// ----------------------------------------------------------------------------
// A reseed or an unused kind goes from acceptance in the idle state through
// the write state to the result register. A raw or range draw is accepted in
// the idle state; in the run state the step unit produces the new w one bit
// per cycle, most significant bit first, while the remainder unit folds the
// low 31 of those bits into the partial remainder in the same cycles; in the
// write state the result is written once the output register is free. One
// transaction is in progress at a time; a finished result waits in the output
// register, and the next request is taken only once the result is written there.
// ----------------------------------------------------------------------------
`default_nettype none

module xorshift128_range_random
  import xrr_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  xrr_in_if.sink    in_i,
  xrr_out_if.source out_o
);

  state_e             state_q, state_d;
  kind_e              kind_q, kind_d, in_kind;
  logic               zero_q, zero_d;
  logic               out_valid_q, out_valid_d;
  logic [WORD_W-1:0]  value_q, value_d;
  logic               err_q, err_d;
  logic               accept, is_draw, out_free, load_out;
  step_ctrl_t         step_ctrl;
  step_stat_t         step_stat;
  logic [WORD_W-1:0]  word;
  logic [LIMIT_W-1:0] rem;

  assign in_kind  = kind_e'(in_i.kind);
  assign accept   = in_i.valid & in_i.ready;
  assign is_draw  = (in_kind == KIND_RAW) | (in_kind == KIND_RANGE);
  assign out_free = ~out_valid_q | out_o.ready;

  xrr_step u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (step_ctrl),
    .seed_i (in_i.seed_word),
    .stat_o (step_stat),
    .word_o (word)
  );

  // A range draw uses only the low 31 bits of the word, so its top bit is skipped.
  xrr_mod u_mod (
    .clk_i   (clk_i),
    .start_i (step_ctrl.start),
    .limit_i (in_i.range_limit),
    .shift_i (step_stat.busy & ~step_stat.first),
    .bit_i   (step_stat.dbit),
    .rem_o   (rem)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = is_draw ? ST_RUN : ST_WRITE;
        end
      end
      ST_RUN: begin
        if (step_stat.last) begin
          state_d = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_i.ready       = 1'b0;
    load_out         = 1'b0;
    step_ctrl.start  = 1'b0;
    step_ctrl.reseed = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_i.ready       = 1'b1;
        step_ctrl.start  = accept & is_draw;
        step_ctrl.reseed = accept & (in_kind == KIND_RESEED);
      end
      ST_WRITE: begin
        load_out = out_free;
      end
      default: begin
        in_i.ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    kind_d      = kind_q;
    zero_d      = zero_q;
    value_d     = value_q;
    err_d       = err_q;
    out_valid_d = out_valid_q;
    if (accept) begin
      kind_d = in_kind;
      zero_d = (in_i.range_limit == '0);
    end
    if (out_valid_q & out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (load_out) begin
      out_valid_d = 1'b1;
      err_d       = 1'b0;
      case (kind_q)
        KIND_RAW:   value_d = word;
        KIND_RANGE: begin
          value_d = zero_q ? '0 : {1'b0, rem};
          err_d   = zero_q;
        end
        default:    value_d = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    zero_q  <= zero_d;
    value_q <= value_d;
    err_q   <= err_d;
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.value       = value_q;
  assign out_o.range_error = err_q;

endmodule

`default_nettype wire

FILE: rtl/core/xrr_checker.sv
// ----------------------------------------------------------------------------
// xorshift128 range random: port checker
// Watches the generator's channels and checks their behaviour over time.
// ----------------------------------------------------------------------------
`default_nettype none

`include "xorshift128_range_random_defines.svh"

module xrr_checker
  import xrr_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_ready_i,
  input wire logic              out_valid_i,
  input wire logic              out_ready_i,
  input wire logic [WORD_W-1:0] out_value_i,
  input wire logic              out_range_error_i
);

  // One transaction at a time: the block is busy right after taking one.
  `XRR_ASSERT(a_busy_after_accept, clk_i, rst_ni, (in_valid_i && in_ready_i) |=> !in_ready_i, "request taken while busy")

  `XRR_ASSERT(a_error_gives_zero, clk_i, rst_ni, (out_valid_i && out_range_error_i) |-> (out_value_i == '0), "range error with a non-zero value")

  `XRR_ASSERT(a_valid_held, clk_i, rst_ni, (out_valid_i && !out_ready_i) |=> out_valid_i, "result withdrawn while stalled")

  `XRR_ASSERT_HOLD(a_value_held, clk_i, rst_ni, out_valid_i && !out_ready_i, out_value_i, "result changed while stalled")

endmodule

bind xorshift128_range_random xrr_checker u_xrr_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_i.valid),
  .in_ready_i        (in_i.ready),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .out_value_i       (out_o.value),
  .out_range_error_i (out_o.range_error)
);

`default_nettype wire

FILE: tb/tb_xorshift128_range_random.sv
// ----------------------------------------------------------------------------
// xorshift128 range random: testbench
// Sends reseed, raw, range and unused-kind requests through the request
// channel and compares every result transaction with a tracked copy of the
// four generator words. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_xorshift128_range_random;
  import xrr_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int unsigned IDLE_PCT     = 13;
  localparam int unsigned RANDOM_ITEMS = 1850;
  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int unsigned DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [WORD_W-1:0] value;
    logic              range_error;
  } draw_t;

  // Tracks the generator words and holds the results still to arrive.
  class prng_tracker;
    logic [WORD_W-1:0] wx, wy, wz, ww;
    draw_t             due[$];
    int unsigned       mismatches;

    function new();
      wx = SEED_X;
      wy = SEED_Y;
      wz = SEED_Z;
      ww = SEED_W;
      mismatches = 0;
    endfunction

    function logic [WORD_W-1:0] advance_words();
      logic [WORD_W-1:0] t;
      t  = wx ^ (wx << SHIFT_A);
      wx = wy;
      wy = wz;
      wz = ww;
      ww = ww ^ (ww >> SHIFT_B) ^ t ^ (t >> SHIFT_C);
      return ww;
    endfunction

    function void note_request(logic [KIND_W-1:0] kind, logic [WORD_W-1:0] seed,
                               logic [LIMIT_W-1:0] limit);
      draw_t             d;
      logic [WORD_W-1:0] w;
      d = '0;
      case (kind)
        KIND_RESEED: begin
          wx = SEED_X;
          wy = SEED_Y;
          wz = SEED_Z;
          ww = seed;
        end
        KIND_RAW: d.value = advance_words();
        KIND_RANGE: begin
          // The generator steps even when the limit is zero.
          w = advance_words();
          if (limit == '0) begin
            d.range_error = 1'b1;
          end else begin
            d.value = {1'b0, w[LIMIT_W-1:0] % limit};
          end
        end
        default: ;
      endcase
      due.push_back(d);
    endfunction

    function void check_result(logic [WORD_W-1:0] value, logic range_error);
      draw_t d;
      if (due.size() == 0) begin
        $error("unexpected result transaction: value %08h range_error %0b",
               value, range_error);
        mismatches++;
        return;
      end
      d = due.pop_front();
      if (value !== d.value) begin
        $error("value: expected %08h, actual %08h", d.value, value);
        mismatches++;
      end
      if (range_error !== d.range_error) begin
        $error("range_error: expected %0b, actual %0b", d.range_error, range_error);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  bit          idle_on = 1'b1;
  int unsigned cycle_count = 0;
  prng_tracker draws = new();

  xrr_in_if  in_ch ();
  xrr_out_if out_ch ();

  xorshift128_range_random dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_xorshift128_range_random: errors");
      $finish;
    end
  end

  // Called at a rising edge; returns at the edge where the request is taken.
  task automatic send_request(input logic [KIND_W-1:0] kind,
                              input logic [WORD_W-1:0] seed,
                              input logic [LIMIT_W-1:0] limit);
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.kind        <= kind;
    in_ch.seed_word   <= seed;
    in_ch.range_limit <= limit;
    do @(posedge clk); while (!in_ch.ready);
    draws.note_request(kind, seed, limit);
  endtask

  // Result side: ready stalls at random, each accepted transaction is checked.
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      out_ch.ready <= !(idle_on && $urandom_range(99) < IDLE_PCT);
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        draws.check_result(out_ch.value, out_ch.range_error);
      end
    end
  end

  initial begin
    logic [KIND_W-1:0]  kind;
    logic [WORD_W-1:0]  seed;
    logic [LIMIT_W-1:0] limit;
    int unsigned        sel;
    int unsigned        counted;

    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.kind        <= KIND_RESEED;
    in_ch.seed_word   <= '0;
    in_ch.range_limit <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: draws from the reset seeds, limit extremes, zero limit,
    // the unused kind and reseeds with extreme seeds.
    send_request(KIND_RAW, '0, '0);
    send_request(KIND_RAW, '1, '1);
    send_request(KIND_RANGE, '0, '1);
    send_request(KIND_RANGE, '0, '0);
    send_request(KIND_RANGE, '1, 31'd1);
    send_request(KIND_RANGE, '0, 31'h4000_0000);
    send_request(KIND_RANGE, '0, 31'd3);
    send_request(KIND_UNUSED, '1, '1);
    send_request(KIND_UNUSED, '0, '0);
    send_request(KIND_RESEED, '0, '1);
    send_request(KIND_RAW, '0, '0);
    send_request(KIND_RANGE, '0, 31'd7);
    send_request(KIND_RESEED, '1, '0);
    send_request(KIND_RAW, '0, '0);
    send_request(KIND_RANGE, '1, '0);
    send_request(KIND_RESEED, SEED_W, 31'd5);
    send_request(KIND_RAW, '0, '0);
    send_request(KIND_RESEED, 32'h8000_0000, '0);
    send_request(KIND_RANGE, '0, 31'h7FFF_FFFE);
    send_request(KIND_RAW, '1, '0);

    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      // A long stretch in the middle runs both channels without idling.
      idle_on = !(counted >= 700 && counted < 1000);
      sel = $urandom_range(99);
      if (sel < 6) begin
        kind = KIND_RESEED;
      end else if (sel < 8) begin
        kind = KIND_UNUSED;
      end else if (sel < 50) begin
        kind = KIND_RAW;
      end else begin
        kind = KIND_RANGE;
      end
      sel = $urandom_range(99);
      if (sel < 5) begin
        seed = '0;
      end else if (sel < 10) begin
        seed = '1;
      end else begin
        seed = $urandom();
      end
      sel = $urandom_range(99);
      if (sel < 8) begin
        limit = '0;
      end else if (sel < 35) begin
        limit = LIMIT_W'($urandom_range(255, 1));
      end else if (sel < 50) begin
        limit = 31'd1 << $urandom_range(LIMIT_W - 1);
      end else if (sel < 55) begin
        limit = '1;
      end else begin
        limit = LIMIT_W'($urandom());
      end
      send_request(kind, seed, limit);
      if (kind != KIND_UNUSED) counted++;
    end
    in_ch.valid <= 1'b0;
    idle_on = 1'b1;

    while (draws.due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (draws.mismatches == 0) begin
      $display("tb_xorshift128_range_random: clean");
    end else begin
      $display("tb_xorshift128_range_random: errors");
    end
    $finish;
  end

endmodule
